FILE: hw/rtl/spi_nor_flash_command_sequencer_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the SPI NOR flash command sequencer
// Simulation-only checks, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SNCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sequencer assertion failed");
`define SNCS_ASSERT_NEVER(lbl, cond) \
  `SNCS_ASSERT(lbl, !(cond))
`else
`define SNCS_ASSERT(lbl, prop)
`define SNCS_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: hw/rtl/sncs_pkg.sv
// ---------------------------------------------------------------------------
// sncs_pkg
// Types, opcodes and the action table of the SPI NOR command sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package sncs_pkg;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned CntW   = 25;
  localparam int unsigned PollW  = 16;
  localparam int unsigned StepW  = 4;

  localparam logic [PollW-1:0] PollLimitReset = 16'd10000;

  // Request codes.
  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_PROG   = 3'd1;
  localparam logic [2:0] REQ_SECTOR = 3'd2;
  localparam logic [2:0] REQ_BLOCK  = 3'd3;
  localparam logic [2:0] REQ_QUERY  = 3'd4;
  localparam logic [2:0] REQ_STATUS = 3'd5;

  // Flash opcodes.
  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_RDSR = 8'h05;
  localparam logic [7:0] OP_READ = 8'h03;
  localparam logic [7:0] OP_PP   = 8'h02;
  localparam logic [7:0] OP_SE   = 8'h20;
  localparam logic [7:0] OP_BE   = 8'hD8;

  typedef enum logic [2:0] {
    ACT_CS_LOW  = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_READ1   = 3'd2,
    ACT_RBURST  = 3'd3,
    ACT_WBURST  = 3'd4,
    ACT_CS_HIGH = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    WAIT_IDLE  = 2'd0,
    WAIT_POLL  = 2'd1,
    WAIT_QUERY = 2'd2
  } wait_e;

  // Kind of action sequence that one accepted item expands into.
  typedef enum logic [2:0] {
    K_READ,
    K_PROG,
    K_ERASE,
    K_QUERY,
    K_POLL_READ,
    K_CLOSE
  } kind_e;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [AddrW-1:0] flash_addr;
    logic [CntW-1:0]  byte_count;
    logic [7:0]       status_in;
  } req_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       op;
    logic [AddrW-1:0] addr;
    logic [CntW-1:0]  cnt;
    logic             busy;
    logic             tmo;
  } plan_t;

  typedef struct packed {
    act_e       act;
    logic [7:0] tx;
    logic       burst;
    logic       done;
    logic       last;
  } row_t;

  typedef struct packed {
    logic [2:0]      spi_action;
    logic [7:0]      tx_byte;
    logic [CntW-1:0] burst_len;
    logic            busy_res;
    logic            timed_out;
    logic            done_res;
    logic            last;
  } res_t;

  function automatic row_t mk_row(act_e act, logic [7:0] tx, logic burst,
                                  logic done, logic last);
    row_t r;
    r.act   = act;
    r.tx    = tx;
    r.burst = burst;
    r.done  = done;
    r.last  = last;
    return r;
  endfunction

  // One action of a sequence, selected by kind and step.
  function automatic row_t seq_row(kind_e kind, logic [StepW-1:0] step,
                                   logic [7:0] op, logic [AddrW-1:0] addr);
    row_t             r;
    logic [StepW-1:0] ps;
    r = mk_row(ACT_CS_HIGH, 8'h00, 1'b0, 1'b1, 1'b1);
    // An erase runs the program sequence without its write burst.
    ps = (kind == K_ERASE && step >= StepW'(8)) ? step + StepW'(1) : step;
    unique case (kind)
      K_READ: begin
        unique case (step)
          4'd0:    r = mk_row(ACT_CS_LOW, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd1:    r = mk_row(ACT_SEND, OP_READ, 1'b0, 1'b0, 1'b0);
          4'd2:    r = mk_row(ACT_SEND, addr[23:16], 1'b0, 1'b0, 1'b0);
          4'd3:    r = mk_row(ACT_SEND, addr[15:8], 1'b0, 1'b0, 1'b0);
          4'd4:    r = mk_row(ACT_SEND, addr[7:0], 1'b0, 1'b0, 1'b0);
          4'd5:    r = mk_row(ACT_RBURST, 8'h00, 1'b1, 1'b0, 1'b0);
          default: r = mk_row(ACT_CS_HIGH, 8'h00, 1'b0, 1'b1, 1'b1);
        endcase
      end
      K_PROG, K_ERASE: begin
        unique case (ps)
          4'd0:    r = mk_row(ACT_CS_LOW, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd1:    r = mk_row(ACT_SEND, OP_WREN, 1'b0, 1'b0, 1'b0);
          4'd2:    r = mk_row(ACT_CS_HIGH, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd3:    r = mk_row(ACT_CS_LOW, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd4:    r = mk_row(ACT_SEND, op, 1'b0, 1'b0, 1'b0);
          4'd5:    r = mk_row(ACT_SEND, addr[23:16], 1'b0, 1'b0, 1'b0);
          4'd6:    r = mk_row(ACT_SEND, addr[15:8], 1'b0, 1'b0, 1'b0);
          4'd7:    r = mk_row(ACT_SEND, addr[7:0], 1'b0, 1'b0, 1'b0);
          4'd8:    r = mk_row(ACT_WBURST, 8'h00, 1'b1, 1'b0, 1'b0);
          4'd9:    r = mk_row(ACT_CS_HIGH, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd10:   r = mk_row(ACT_CS_LOW, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd11:   r = mk_row(ACT_SEND, OP_RDSR, 1'b0, 1'b0, 1'b0);
          default: r = mk_row(ACT_READ1, 8'h00, 1'b0, 1'b0, 1'b1);
        endcase
      end
      K_QUERY: begin
        unique case (step)
          4'd0:    r = mk_row(ACT_CS_LOW, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd1:    r = mk_row(ACT_SEND, OP_RDSR, 1'b0, 1'b0, 1'b0);
          default: r = mk_row(ACT_READ1, 8'h00, 1'b0, 1'b0, 1'b1);
        endcase
      end
      K_POLL_READ: r = mk_row(ACT_READ1, 8'h00, 1'b0, 1'b0, 1'b1);
      default:     r = mk_row(ACT_CS_HIGH, 8'h00, 1'b0, 1'b1, 1'b1);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sncs_if.sv
// ---------------------------------------------------------------------------
// sncs_req_if / sncs_res_if
// Valid/ready channels for flash requests and for SPI action items.
// ---------------------------------------------------------------------------
`default_nettype none

interface sncs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [23:0] flash_addr;
  logic [24:0] byte_count;
  logic [7:0]  status_in;

  modport source (output valid, req_type, flash_addr, byte_count, status_in,
                  input ready);
  modport sink   (input valid, req_type, flash_addr, byte_count, status_in,
                  output ready);
endinterface

interface sncs_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  spi_action;
  logic [7:0]  tx_byte;
  logic [24:0] burst_len;
  logic        busy_res;
  logic        timed_out;
  logic        done_res;
  logic        last;

  modport source (output valid, spi_action, tx_byte, burst_len, busy_res,
                  timed_out, done_res, last, input ready);
  modport sink   (input valid, spi_action, tx_byte, burst_len, busy_res,
                  timed_out, done_res, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sncs_decode.sv
// ---------------------------------------------------------------------------
// sncs_decode
// Holds the wait mode, poll counter and poll limit, and turns each accepted
// request that calls for actions into the plan of the action sequence.
// ---------------------------------------------------------------------------
`default_nettype none

module sncs_decode
  import sncs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [PollW-1:0] cfg_wdata_i,
  input  wire logic             acc_i,
  input  wire req_t             req_i,
  output plan_t                 plan_o,
  output logic                  plan_vld_o
);

  wait_e             wait_q, wait_d;
  logic [PollW-1:0]  poll_cnt_q, poll_cnt_d;
  logic [PollW-1:0]  poll_limit_q;
  logic [PollW-1:0]  poll_inc;

  assign poll_inc = (poll_cnt_q == '1) ? poll_cnt_q : poll_cnt_q + PollW'(1);

  always_comb begin
    wait_d      = wait_q;
    poll_cnt_d  = poll_cnt_q;
    plan_vld_o  = 1'b0;
    plan_o.kind = K_CLOSE;
    plan_o.op   = OP_PP;
    plan_o.addr = req_i.flash_addr;
    plan_o.cnt  = req_i.byte_count;
    plan_o.busy = 1'b0;
    plan_o.tmo  = 1'b0;
    if (req_i.req_type == REQ_STATUS) begin
      unique case (wait_q)
        WAIT_POLL: begin
          poll_cnt_d = poll_inc;
          plan_vld_o = 1'b1;
          if (!req_i.status_in[0]) begin
            wait_d = WAIT_IDLE;
          end else if (poll_inc >= poll_limit_q) begin
            plan_o.busy = 1'b1;
            plan_o.tmo  = 1'b1;
            wait_d      = WAIT_IDLE;
          end else begin
            plan_o.kind = K_POLL_READ;
          end
        end
        WAIT_QUERY: begin
          plan_vld_o  = 1'b1;
          plan_o.busy = req_i.status_in[0];
          wait_d      = WAIT_IDLE;
        end
        default: ;
      endcase
    end else if (wait_q == WAIT_IDLE) begin
      // Unknown request codes fall through with no plan.
      priority if (req_i.req_type == REQ_READ) begin
        plan_vld_o  = 1'b1;
        plan_o.kind = K_READ;
      end else if (req_i.req_type == REQ_QUERY) begin
        plan_vld_o  = 1'b1;
        plan_o.kind = K_QUERY;
        wait_d      = WAIT_QUERY;
      end else if (req_i.req_type == REQ_PROG || req_i.req_type == REQ_SECTOR ||
                   req_i.req_type == REQ_BLOCK) begin
        plan_vld_o  = 1'b1;
        plan_o.kind = (req_i.req_type == REQ_PROG) ? K_PROG : K_ERASE;
        plan_o.op   = (req_i.req_type == REQ_PROG)   ? OP_PP :
                      (req_i.req_type == REQ_SECTOR) ? OP_SE : OP_BE;
        wait_d      = WAIT_POLL;
        poll_cnt_d  = '0;
      end else begin
        plan_vld_o = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q     <= WAIT_IDLE;
      poll_cnt_q <= '0;
    end else if (acc_i) begin
      wait_q     <= wait_d;
      poll_cnt_q <= poll_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= PollLimitReset;
    end else if (cfg_we_i) begin
      poll_limit_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sncs_seq.sv
// ---------------------------------------------------------------------------
// sncs_seq
// Plan register, step counter and output register: plays out one action
// per cycle of the current plan while the output is not stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module sncs_seq
  import sncs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire plan_t plan_i,
  input  wire logic  plan_load_i,
  output logic       in_ready_o,
  output res_t       res_o,
  output logic       res_vld_o,
  input  wire logic  res_rdy_i
);

  plan_t            plan_q;
  logic             plan_vld_q;
  logic [StepW-1:0] step_q;
  logic             out_vld_q;
  res_t             res_q, res_d;
  row_t             row;
  logic             move;
  logic             fin;

  assign row        = seq_row(plan_q.kind, step_q, plan_q.op, plan_q.addr);
  assign move       = plan_vld_q && (!out_vld_q || res_rdy_i);
  assign fin        = move && row.last;
  assign in_ready_o = !plan_vld_q || fin;

  always_comb begin
    res_d.spi_action = row.act;
    res_d.tx_byte    = row.tx;
    res_d.burst_len  = row.burst ? plan_q.cnt : '0;
    res_d.busy_res   = (plan_q.kind == K_CLOSE) && plan_q.busy;
    res_d.timed_out  = (plan_q.kind == K_CLOSE) && plan_q.tmo;
    res_d.done_res   = row.done;
    res_d.last       = row.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_vld_q <= 1'b0;
      step_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (plan_load_i) begin
        plan_vld_q <= 1'b1;
        step_q     <= '0;
      end else if (fin) begin
        plan_vld_q <= 1'b0;
      end else if (move) begin
        step_q <= step_q + StepW'(1);
      end
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (res_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (plan_load_i) begin
      plan_q <= plan_i;
    end
    if (move) begin
      res_q <= res_d;
    end
  end

  assign res_o     = res_q;
  assign res_vld_o = out_vld_q;

endmodule

`default_nettype wire

FILE: hw/rtl/spi_nor_flash_command_sequencer_unit.sv
// ---------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_unit
// Expands flash requests into SPI action items and tracks status polling.
// ---------------------------------------------------------------------------
//  Channel  Direction  Moves
//  req_i    in         one flash request or returned status byte per item
//  res_o    out        one SPI action per item, last marks the end of a request
//  cfg      in         poll limit write (cfg_we_i, cfg_wdata_i)
//
// A request is taken and its plan is played out by the step counter, one
// action item per cycle unless the output stalls: 7 for a read, 13 for a
// program, 12 for an erase, 3 for a status query, 1 for a status byte. The
// next request is taken in the cycle the last action of the current one
// enters the output register. A stalled output holds the register and the
// step counter. Reset returns to idle with a poll limit of 10000.
`default_nettype none

`include "spi_nor_flash_command_sequencer_unit_assert.svh"

module spi_nor_flash_command_sequencer_unit
  import sncs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  sncs_req_if.sink         req_i,
  sncs_res_if.source       res_o
);

  req_t  req;
  plan_t plan;
  logic  plan_vld;
  logic  in_ready;
  logic  acc;
  res_t  res;
  logic  res_vld;

  assign req.req_type   = req_i.req_type;
  assign req.flash_addr = req_i.flash_addr;
  assign req.byte_count = req_i.byte_count;
  assign req.status_in  = req_i.status_in;

  assign req_i.ready = in_ready;
  assign acc         = req_i.valid && in_ready;

  sncs_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .req_i       (req),
    .plan_o      (plan),
    .plan_vld_o  (plan_vld)
  );

  sncs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .plan_i      (plan),
    .plan_load_i (acc && plan_vld),
    .in_ready_o  (in_ready),
    .res_o       (res),
    .res_vld_o   (res_vld),
    .res_rdy_i   (res_o.ready)
  );

  assign res_o.valid      = res_vld;
  assign res_o.spi_action = res.spi_action;
  assign res_o.tx_byte    = res.tx_byte;
  assign res_o.burst_len  = res.burst_len;
  assign res_o.busy_res   = res.busy_res;
  assign res_o.timed_out  = res.timed_out;
  assign res_o.done_res   = res.done_res;
  assign res_o.last       = res.last;

  // A timeout always closes the status frame and reports busy and done.
  `SNCS_ASSERT(a_tmo_close, res_o.valid && res_o.timed_out |-> res_o.busy_res && res_o.done_res && res_o.last && res_o.spi_action == ACT_CS_HIGH)
  // Only burst actions carry a length.
  `SNCS_ASSERT_NEVER(a_len_burst, res_o.valid && res_o.burst_len != '0 && res_o.spi_action != ACT_RBURST && res_o.spi_action != ACT_WBURST)
  // Only send actions carry a byte.
  `SNCS_ASSERT_NEVER(a_tx_send, res_o.valid && res_o.tx_byte != '0 && res_o.spi_action != ACT_SEND)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: SPI NOR flash command sequencer testbench
// Drives flash requests and returned status bytes into the sequencer through
// valid/ready channels and checks every SPI action item that comes back
// against a cycle-free prediction of the action sequence and the status
// polling. It runs directed items first, then random items under several
// poll limits, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
import sncs_pkg::*;

class spi_action_scoreboard;
  logic [PollW-1:0] poll_limit;
  wait_e            wait_mode;
  logic [PollW-1:0] poll_count;
  res_t             expected_actions[$];
  int unsigned      errors;
  int unsigned      acted_items;

  function new();
    poll_limit  = PollLimitReset;
    wait_mode   = WAIT_IDLE;
    poll_count  = '0;
    errors      = 0;
    acted_items = 0;
  endfunction

  function void push_action(act_e act, logic [7:0] tx, logic [CntW-1:0] len,
                            logic busy, logic tmo, logic done, logic is_last);
    res_t a;
    a.spi_action = act;
    a.tx_byte    = tx;
    a.burst_len  = len;
    a.busy_res   = busy;
    a.timed_out  = tmo;
    a.done_res   = done;
    a.last       = is_last;
    expected_actions.push_back(a);
  endfunction

  function void push_addr(logic [AddrW-1:0] addr);
    push_action(ACT_SEND, addr[23:16], '0, 1'b0, 1'b0, 1'b0, 1'b0);
    push_action(ACT_SEND, addr[15:8], '0, 1'b0, 1'b0, 1'b0, 1'b0);
    push_action(ACT_SEND, addr[7:0], '0, 1'b0, 1'b0, 1'b0, 1'b0);
  endfunction

  // Works out the SPI actions that one accepted request item causes.
  function void note_request(req_t r);
    int unsigned before_cnt;
    logic [7:0]  op;
    before_cnt = expected_actions.size();
    if (r.req_type == REQ_STATUS) begin
      if (wait_mode == WAIT_POLL) begin
        if (poll_count != '1) poll_count++;
        if (!r.status_in[0]) begin
          push_action(ACT_CS_HIGH, 8'h00, '0, 1'b0, 1'b0, 1'b1, 1'b1);
          wait_mode = WAIT_IDLE;
        end else if (poll_count >= poll_limit) begin
          push_action(ACT_CS_HIGH, 8'h00, '0, 1'b1, 1'b1, 1'b1, 1'b1);
          wait_mode = WAIT_IDLE;
        end else begin
          push_action(ACT_READ1, 8'h00, '0, 1'b0, 1'b0, 1'b0, 1'b1);
        end
      end else if (wait_mode == WAIT_QUERY) begin
        push_action(ACT_CS_HIGH, 8'h00, '0, r.status_in[0], 1'b0, 1'b1, 1'b1);
        wait_mode = WAIT_IDLE;
      end
    end else if (wait_mode == WAIT_IDLE) begin
      case (r.req_type)
        REQ_READ: begin
          push_action(ACT_CS_LOW, 8'h00, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_SEND, OP_READ, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_addr(r.flash_addr);
          push_action(ACT_RBURST, 8'h00, r.byte_count, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_CS_HIGH, 8'h00, '0, 1'b0, 1'b0, 1'b1, 1'b1);
        end
        REQ_QUERY: begin
          push_action(ACT_CS_LOW, 8'h00, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_SEND, OP_RDSR, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_READ1, 8'h00, '0, 1'b0, 1'b0, 1'b0, 1'b1);
          wait_mode = WAIT_QUERY;
        end
        REQ_PROG, REQ_SECTOR, REQ_BLOCK: begin
          op = (r.req_type == REQ_PROG) ? OP_PP :
               (r.req_type == REQ_SECTOR) ? OP_SE : OP_BE;
          push_action(ACT_CS_LOW, 8'h00, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_SEND, OP_WREN, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_CS_HIGH, 8'h00, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_CS_LOW, 8'h00, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_SEND, op, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_addr(r.flash_addr);
          if (r.req_type == REQ_PROG)
            push_action(ACT_WBURST, 8'h00, r.byte_count, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_CS_HIGH, 8'h00, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_CS_LOW, 8'h00, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_SEND, OP_RDSR, '0, 1'b0, 1'b0, 1'b0, 1'b0);
          push_action(ACT_READ1, 8'h00, '0, 1'b0, 1'b0, 1'b0, 1'b1);
          wait_mode  = WAIT_POLL;
          poll_count = '0;
        end
        default: ;
      endcase
    end
    if (expected_actions.size() != before_cnt) acted_items++;
  endfunction

  function void compare_field(string name, longint unsigned want,
                              longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_action(res_t got);
    res_t want;
    if (expected_actions.size() == 0) begin
      $error("unexpected spi action item: action %0d tx 0x%0h",
             got.spi_action, got.tx_byte);
      errors++;
      return;
    end
    want = expected_actions.pop_front();
    compare_field("spi_action", want.spi_action, got.spi_action);
    compare_field("tx_byte", want.tx_byte, got.tx_byte);
    compare_field("burst_len", want.burst_len, got.burst_len);
    compare_field("busy_res", want.busy_res, got.busy_res);
    compare_field("timed_out", want.timed_out, got.timed_out);
    compare_field("done_res", want.done_res, got.done_res);
    compare_field("last", want.last, got.last);
  endfunction

  function int unsigned pending();
    return expected_actions.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]      REQ_UNKNOWN_LO = 3'd6;
  localparam logic [2:0]      REQ_UNKNOWN_HI = 3'd7;
  localparam logic [7:0]      BusyMask       = 8'h01;
  localparam logic [CntW-1:0] MaxCount       = 25'h1000000;
  localparam logic [PollW-1:0] MaxLimit      = 16'hFFFF;
  localparam logic [PollW-1:0] ExhaustMax    = 16'd40;
  localparam int unsigned     RandomPerPhase = 25;
  localparam int unsigned     NumPhases      = 7;
  localparam longint unsigned CycleLimit     = 4000000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  sncs_req_if req_if ();
  sncs_res_if res_if ();

  spi_nor_flash_command_sequencer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  spi_action_scoreboard sb;
  int unsigned          burst_left = 0;
  longint unsigned      cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("spi_nor_flash_command_sequencer_unit test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin : monitor
    req_t rq;
    res_t rs;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        rq.req_type   = req_if.req_type;
        rq.flash_addr = req_if.flash_addr;
        rq.byte_count = req_if.byte_count;
        rq.status_in  = req_if.status_in;
        sb.note_request(rq);
      end
      if (res_if.valid && res_if.ready) begin
        rs.spi_action = res_if.spi_action;
        rs.tx_byte    = res_if.tx_byte;
        rs.burst_len  = res_if.burst_len;
        rs.busy_res   = res_if.busy_res;
        rs.timed_out  = res_if.timed_out;
        rs.done_res   = res_if.done_res;
        rs.last       = res_if.last;
        sb.check_action(rs);
      end
    end
  end

  // The receiver stalls on a rotating 8-bit pattern that changes now and then.
  // Every pattern has bits 0 and 4 set, so no pattern keeps ready low for good.
  initial begin : receiver
    logic [7:0]  stall_pattern;
    int unsigned pattern_left;
    res_if.ready  = 1'b0;
    stall_pattern = 8'hFF;
    pattern_left  = 0;
    forever begin
      @(negedge clk_i);
      if (pattern_left == 0) begin
        stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom()) | 8'h11);
        pattern_left  = $urandom_range(16, 200);
      end
      pattern_left--;
      res_if.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
    end
  end

  function automatic req_t make_req(logic [2:0] kind, logic [AddrW-1:0] addr,
                                    logic [CntW-1:0] cnt, logic [7:0] st);
    req_t r;
    r.req_type   = kind;
    r.flash_addr = addr;
    r.byte_count = cnt;
    r.status_in  = st;
    return r;
  endfunction

  // Mostly well-formed traffic: requests while idle, status bytes while a poll
  // or query is open, with some items that the sequencer has to ignore.
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    r.flash_addr = AddrW'($urandom());
    r.status_in  = 8'($urandom());
    case ($urandom_range(0, 3))
      0:       r.byte_count = MaxCount;
      1:       r.byte_count = CntW'($urandom_range(0, 64));
      default: r.byte_count = CntW'($urandom_range(0, MaxCount));
    endcase
    pick = $urandom_range(0, 99);
    if (sb.wait_mode == WAIT_IDLE) begin
      if (pick < 88)      r.req_type = 3'($urandom_range(REQ_READ, REQ_QUERY));
      else if (pick < 94) r.req_type = REQ_STATUS;
      else                r.req_type = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
    end else if (pick < 85) begin
      r.req_type = REQ_STATUS;
      r.status_in[0] = ($urandom_range(0, 99) < 55);
    end else begin
      r.req_type = 3'($urandom());
    end
    return r;
  endfunction

  // Called and returning at a falling edge; the item is accepted in between.
  task automatic send_item(req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_if.valid      <= 1'b1;
    req_if.req_type   <= r.req_type;
    req_if.flash_addr <= r.flash_addr;
    req_if.byte_count <= r.byte_count;
    req_if.status_in  <= r.status_in;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic settle(int unsigned tail);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic write_poll_limit(logic [PollW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.poll_limit = value;
  endtask

  task automatic close_open_wait();
    while (sb.wait_mode != WAIT_IDLE)
      send_item(make_req(REQ_STATUS, '0, '0, 8'h00));
  endtask

  // Keeps the flash busy until the poll gives up with a timeout.
  task automatic exhaust_poll_limit();
    send_item(make_req(REQ_PROG, AddrW'($urandom()), CntW'($urandom_range(0, 64)),
                       8'h00));
    while (sb.wait_mode != WAIT_IDLE)
      send_item(make_req(REQ_STATUS, '0, '0, 8'($urandom()) | BusyMask));
  endtask

  initial begin : stimulus
    logic [PollW-1:0] limit_plan [NumPhases];
    int unsigned      target;
    sb = new();
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_READ;
    req_if.flash_addr = '0;
    req_if.byte_count = '0;
    req_if.status_in  = '0;
    limit_plan = '{16'd0, 16'd1, 16'd2, 16'd3, 16'($urandom_range(4, 40)),
                   MaxLimit, 16'd257};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items at the reset poll limit.
    send_item(make_req(REQ_READ, 24'h000000, '0, 8'h00));
    send_item(make_req(REQ_READ, 24'hFFFFFF, MaxCount, 8'hFF));
    send_item(make_req(REQ_READ, 24'h5AA53C, 25'd1, 8'h00));
    send_item(make_req(REQ_QUERY, 24'h000000, '0, 8'h00));
    send_item(make_req(REQ_STATUS, 24'h000000, '0, 8'h00));
    send_item(make_req(REQ_QUERY, 24'hFFFFFF, MaxCount, 8'h00));
    // A new request while the query is open must be dropped.
    send_item(make_req(REQ_READ, 24'h123456, 25'd16, 8'h00));
    send_item(make_req(REQ_STATUS, 24'h000000, '0, 8'hFF));
    send_item(make_req(REQ_PROG, 24'h123456, MaxCount, 8'h00));
    send_item(make_req(REQ_STATUS, 24'h000000, '0, 8'h01));
    send_item(make_req(REQ_SECTOR, 24'h00FF00, '0, 8'h00));
    send_item(make_req(REQ_STATUS, 24'h000000, '0, 8'h03));
    send_item(make_req(REQ_STATUS, 24'hFFFFFF, MaxCount, 8'hFE));
    send_item(make_req(REQ_SECTOR, 24'hFFFFFF, MaxCount, 8'h00));
    send_item(make_req(REQ_STATUS, 24'h000000, '0, 8'h00));
    send_item(make_req(REQ_BLOCK, 24'h000000, '0, 8'h00));
    send_item(make_req(REQ_STATUS, 24'h000000, '0, 8'hFF));
    send_item(make_req(REQ_STATUS, 24'h000000, '0, 8'h80));
    // Status bytes and unknown codes while idle cause nothing.
    send_item(make_req(REQ_STATUS, 24'h000000, '0, 8'h01));
    send_item(make_req(REQ_UNKNOWN_LO, 24'hFFFFFF, MaxCount, 8'hFF));
    send_item(make_req(REQ_UNKNOWN_HI, 24'h000000, '0, 8'h00));
    send_item(make_req(REQ_PROG, 24'hFFFFFF, '0, 8'h00));
    send_item(make_req(REQ_STATUS, 24'h000000, '0, 8'h00));

    foreach (limit_plan[i]) begin
      settle(8);
      write_poll_limit(limit_plan[i]);
      if (limit_plan[i] <= ExhaustMax) exhaust_poll_limit();
      target = sb.acted_items + RandomPerPhase;
      while (sb.acted_items < target) send_item(random_request());
      close_open_wait();
    end

    settle(20);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("spi_nor_flash_command_sequencer_unit test passed");
    end else begin
      $display("spi_nor_flash_command_sequencer_unit test failed");
    end
    $finish;
  end
endmodule
